### rtl/ljd_pkg.sv
// Package for the ladder joystick decoder: direction, repeat and register
// codes, register reset values and the step encoding.
// No dependencies.
package ljd_pkg;

	localparam int unsigned RawW  = 16;
	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;

	// Register reset values
	localparam logic [CfgW-1:0] PressLimitRst  = 16'd3500;
	localparam logic [CfgW-1:0] LeftLimitRst   = 16'd10000;
	localparam logic [CfgW-1:0] RightLimitRst  = 16'd23000;
	localparam logic [CfgW-1:0] UpLimitRst     = 16'd36000;
	localparam logic [CfgW-1:0] DownLimitRst   = 16'd50000;
	localparam logic [CfgW-1:0] FirstDelayRst  = 16'd260;
	localparam logic [CfgW-1:0] RepeatRst      = 16'd110;
	localparam logic [RawW-1:0] HeldRawRst     = 16'hFFFF;

	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_PRESS = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_RIGHT = 3'd3,
		DIR_UP    = 3'd4,
		DIR_DOWN  = 3'd5
	} dir_t;

	typedef enum logic [1:0] {
		REP_NONE  = 2'd0,
		REP_LEFT  = 2'd1,
		REP_RIGHT = 2'd2
	} rep_t;

	typedef enum logic [2:0] {
		CFG_PRESS_LIMIT  = 3'd0,
		CFG_LEFT_LIMIT   = 3'd1,
		CFG_RIGHT_LIMIT  = 3'd2,
		CFG_UP_LIMIT     = 3'd3,
		CFG_DOWN_LIMIT   = 3'd4,
		CFG_FIRST_DELAY  = 3'd5,
		CFG_REPEAT_PER   = 3'd6
	} cfg_idx_t;

	// Two's complement step codes
	localparam logic signed [1:0] STEP_ZERO = 2'sd0;
	localparam logic signed [1:0] STEP_POS  = 2'sd1;
	localparam logic signed [1:0] STEP_NEG  = -2'sd1;

endpackage

### rtl/ladder_joystick_decode_autorepeat.sv
// Ladder joystick decoder with typematic left/right stepping, top level.
// Depends on ljd_pkg.
//
// Usage:
//  - s_* channel: one converter sample per item. s_tdata holds adc_sample
//    and now_ms, s_tuser the good-conversion flag. A bad conversion keeps
//    the previously held sample.
//  - m_* channel: exactly one result item per input item: decoded
//    direction, held sample and a -1/0/+1 step for left/right.
//  - cfg_* channel: register writes (index 0..6 as in cfg_idx_t of
//    ljd_pkg), always ready. Unknown indexes are dropped. Write only while
//    no item is in flight.
//  - Path: input register, then output register, then m_*. Throughput:
//    one item per clock while m_tready is high; the held sample, repeat
//    direction and next deadline are updated as the item leaves the input
//    register, so the following item sees them in the very next cycle.
//  - Stall: the output register holds its item while m_tready is low; the
//    input register still takes one more item, then s_tready drops.
//  - Reset (arst_n low): limits and delays return to defaults, held sample
//    goes to 0xFFFF, repeat state to none, both stages empty.
module ladder_joystick_decode_autorepeat
	import ljd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// sample items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] adc_sample, [47:16] now_ms
	input  logic        s_tuser,   // [0] sample_ok
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] direction, [18:3] held_sample,
	                               // [20:19] step, [23:21] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [CfgW-1:0] press_limit_q, left_limit_q, right_limit_q;
	logic [CfgW-1:0] up_limit_q, down_limit_q, first_delay_q, repeat_per_q;

	// decoder state
	logic [RawW-1:0]  held_q;
	rep_t             rep_q;
	logic [TimeW-1:0] next_time_q;

	// input register
	logic             valid_s1;
	logic [RawW-1:0]  sample_s1;
	logic             ok_s1;
	logic [TimeW-1:0] now_s1;

	// output register
	logic             m_tvalid_q;
	dir_t             dir_q;
	logic [RawW-1:0]  held_out_q;
	logic signed [1:0] step_q;

	logic adv_s1, take_in;

	// combinational decode of the item in the input register
	logic [RawW-1:0]   held_c;
	dir_t              dir_c;
	rep_t              rep_c;
	rep_t              rep_nx;
	logic [TimeW-1:0]  next_nx;
	logic [TimeW-1:0]  diff_c;
	logic              due_c;
	logic signed [1:0] step_c;

	assign cfg_ready = 1'b1;

	assign adv_s1   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_limit_q <= PressLimitRst;
			left_limit_q  <= LeftLimitRst;
			right_limit_q <= RightLimitRst;
			up_limit_q    <= UpLimitRst;
			down_limit_q  <= DownLimitRst;
			first_delay_q <= FirstDelayRst;
			repeat_per_q  <= RepeatRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRESS_LIMIT: press_limit_q <= cfg_data;
				CFG_LEFT_LIMIT:  left_limit_q  <= cfg_data;
				CFG_RIGHT_LIMIT: right_limit_q <= cfg_data;
				CFG_UP_LIMIT:    up_limit_q    <= cfg_data;
				CFG_DOWN_LIMIT:  down_limit_q  <= cfg_data;
				CFG_FIRST_DELAY: first_delay_q <= cfg_data;
				CFG_REPEAT_PER:  repeat_per_q  <= cfg_data;
				default: ;  // index beyond the list: dropped
			endcase
		end
	end

	// Threshold chain is a priority: first limit not exceeded wins.
	always_comb begin
		held_c = ok_s1 ? sample_s1 : held_q;
		priority if (held_c <= press_limit_q) dir_c = DIR_PRESS;
		else if (held_c <= left_limit_q)     dir_c = DIR_LEFT;
		else if (held_c <= right_limit_q)    dir_c = DIR_RIGHT;
		else if (held_c <= up_limit_q)       dir_c = DIR_UP;
		else if (held_c <= down_limit_q)     dir_c = DIR_DOWN;
		else                                 dir_c = DIR_NONE;
	end

	// Typematic repeat: step at once on a new direction, then on each
	// deadline. Deadline test is the sign of the wrapped difference.
	always_comb begin
		rep_c   = (dir_c == DIR_LEFT) ? REP_LEFT : REP_RIGHT;
		diff_c  = now_s1 - next_time_q;
		due_c   = !diff_c[TimeW-1];
		rep_nx  = rep_q;
		next_nx = next_time_q;
		step_c  = STEP_ZERO;
		if (dir_c != DIR_LEFT && dir_c != DIR_RIGHT) begin
			rep_nx  = REP_NONE;
			next_nx = now_s1 + {{(TimeW-CfgW){1'b0}}, first_delay_q};
		end else if (rep_c != rep_q) begin
			rep_nx  = rep_c;
			next_nx = now_s1 + {{(TimeW-CfgW){1'b0}}, first_delay_q};
			step_c  = (dir_c == DIR_LEFT) ? STEP_NEG : STEP_POS;
		end else if (due_c) begin
			next_nx = now_s1 + {{(TimeW-CfgW){1'b0}}, repeat_per_q};
			step_c  = (dir_c == DIR_LEFT) ? STEP_NEG : STEP_POS;
		end
	end

	// control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			held_q      <= HeldRawRst;
			rep_q       <= REP_NONE;
			next_time_q <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				m_tvalid_q  <= 1'b1;
				held_q      <= held_c;
				rep_q       <= rep_nx;
				next_time_q <= next_nx;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= s_tdata[15:0];
			now_s1    <= s_tdata[47:16];
			ok_s1     <= s_tuser;
		end
		if (adv_s1) begin
			dir_q      <= dir_c;
			held_out_q <= held_c;
			step_q     <= step_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, step_q, held_out_q, dir_q};

	// ---- assertions ----
	a_step_only_lr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && step_q != STEP_ZERO |-> dir_q == DIR_LEFT || dir_q == DIR_RIGHT)
		else $error("step without left/right direction");

	a_step_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && dir_q == DIR_LEFT |-> step_q != STEP_POS)
		else $error("left direction gave a positive step");

	a_rep_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && dir_c != DIR_LEFT && dir_c != DIR_RIGHT |=> rep_q == REP_NONE)
		else $error("repeat state not cleared on other direction");

	a_new_dir_steps: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (dir_c == DIR_LEFT || dir_c == DIR_RIGHT) && rep_c != rep_q
		|=> step_q != STEP_ZERO)
		else $error("new left/right direction did not step");

endmodule
